FILE: rtl/mibm_pkg.sv
// ============================================================================
// mibm_pkg - shared types and constants of the misc instruction / block move unit
// Opcode values, result kinds, event codes and the result beat layout.
// ============================================================================
`default_nettype none

package mibm_pkg;

    // Input item kinds
    localparam logic ITEM_INSTR = 1'b0;
    localparam logic ITEM_DATA  = 1'b1;

    // Opcodes handled here
    localparam logic [7:0] OP_XBA = 8'hEB;
    localparam logic [7:0] OP_STP = 8'hDB;
    localparam logic [7:0] OP_WAI = 8'hCB;
    localparam logic [7:0] OP_WDM = 8'h42;
    localparam logic [7:0] OP_NOP = 8'hEA;
    localparam logic [7:0] OP_MVP = 8'h44;
    localparam logic [7:0] OP_MVN = 8'h54;

    // Move ends once the count wraps to this value
    localparam logic [15:0] COUNT_END = 16'hFFFF;

    // Result kinds
    localparam logic [1:0] KIND_DONE    = 2'd0;
    localparam logic [1:0] KIND_DONE_NZ = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_WRITE   = 2'd3;

    // Events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_STOP  = 2'd1;
    localparam logic [1:0] EV_WAIT  = 2'd2;
    localparam logic [1:0] EV_UNEXP = 2'd3;

    // Cycle charges
    localparam logic [2:0] CYC_NONE  = 3'd0;
    localparam logic [2:0] CYC_TWO   = 3'd2;
    localparam logic [2:0] CYC_THREE = 3'd3;
    localparam logic [2:0] CYC_BYTE  = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] addr;
        logic [7:0]  wdata;
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  dbank;
        logic [1:0]  nz;
        logic [1:0]  pc_adv;
        logic [2:0]  cyc;
        logic [1:0]  ev;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/misc_instruction_and_block_move_unit_core.sv
// ============================================================================
// misc_instruction_and_block_move_unit_core - XBA/STP/WAI/WDM/NOP/MVP/MVN unit
// Executes the miscellaneous 65C816 instructions and sequences block moves
// as bus read / bus write requests, one beat per result.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | opcode, instruction, dest_bank, src_bank,
//          |                      | acc_in, x_in, y_in, read_data
//  out     | out_valid / out_stall| result_kind, bus_address, write_data,
//          |                      | acc_out, x_out, y_out, data_bank, nz_flags,
//          |                      | pc_advance, cycles, event_res, last
//
//  An accepted beat is held in the input register, then its results
//  (none, one or two) are formed in one pass and loaded into a two-slot
//  result buffer. Items with one result flow at one per cycle while the
//  output is not stalled; a returned move byte yields two results, and
//  the next item waits for the second. The input register drains whenever
//  the buffer is empty or its last beat leaves this cycle. Reset clears
//  all control and move state; out_stall holds the buffered beat unchanged.
`default_nettype none

module misc_instruction_and_block_move_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  instruction,
    input  wire logic [7:0]  dest_bank,
    input  wire logic [7:0]  src_bank,
    input  wire logic [15:0] acc_in,
    input  wire logic [15:0] x_in,
    input  wire logic [15:0] y_in,
    input  wire logic [7:0]  read_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [23:0]      bus_address,
    output logic [7:0]       write_data,
    output logic [15:0]      acc_out,
    output logic [15:0]      x_out,
    output logic [15:0]      y_out,
    output logic [7:0]       data_bank,
    output logic [1:0]       nz_flags,
    output logic [1:0]       pc_advance,
    output logic [2:0]       cycles,
    output logic [1:0]       event_res,
    output logic             last
);

    import mibm_pkg::*;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_full_reg, in_full_next;
    logic        op_reg;
    logic [7:0]  instr_reg;
    logic [7:0]  dbank_in_reg;
    logic [7:0]  sbank_in_reg;
    logic [15:0] acc_reg;
    logic [15:0] x_reg;
    logic [15:0] y_reg;
    logic [7:0]  rdata_reg;

    // ------------------------------------------------------------------
    // Move state
    // ------------------------------------------------------------------
    logic        moving_reg, moving_next;
    logic        down_reg, down_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] src_off_reg, src_off_next;
    logic [15:0] dst_off_reg, dst_off_next;
    logic [7:0]  sbank_reg, sbank_next;
    logic [7:0]  dbank_reg, dbank_next;

    // ------------------------------------------------------------------
    // Result buffer: slot0 is the head shown on the output
    // ------------------------------------------------------------------
    logic [1:0]  cnt_reg, cnt_next;
    result_t     slot0_reg, slot0_next;
    result_t     slot1_reg, slot1_next;

    logic        in_accept;
    logic        out_accept;
    logic        buf_free;
    logic        advance;

    result_t     res0, res1;
    logic [1:0]  res_n;
    logic [15:0] src_step, dst_step, remain_dec;
    logic [7:0]  acc_hi;

    assign out_accept = out_valid && !out_stall;
    // Buffer can take a new pair when empty or its final beat leaves now
    assign buf_free   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_accept);
    assign advance    = in_full_reg && buf_free;
    assign in_stall   = in_full_reg && !buf_free;
    assign in_accept  = in_valid && !in_stall;
    assign in_full_next = in_accept || (in_full_reg && !advance);

    // ------------------------------------------------------------------
    // Single-pass result formation
    // ------------------------------------------------------------------
    always_comb
    begin
        src_step   = down_reg ? (src_off_reg - 16'd1) : (src_off_reg + 16'd1);
        dst_step   = down_reg ? (dst_off_reg - 16'd1) : (dst_off_reg + 16'd1);
        remain_dec = remain_reg - 16'd1;
        acc_hi     = acc_reg[15:8];

        res0  = '0;
        res1  = '0;
        res_n = 2'd0;

        moving_next  = moving_reg;
        down_next    = down_reg;
        remain_next  = remain_reg;
        src_off_next = src_off_reg;
        dst_off_next = dst_off_reg;
        sbank_next   = sbank_reg;
        dbank_next   = dbank_reg;

        if (op_reg == ITEM_DATA)
        begin
            // Drop a returned byte when no move is running
            if (moving_reg)
            begin
                src_off_next = src_step;
                dst_off_next = dst_step;
                remain_next  = remain_dec;
                res_n        = 2'd2;

                res0.kind   = KIND_WRITE;
                res0.addr   = {dbank_reg, dst_off_reg};
                res0.wdata  = rdata_reg;
                res0.acc    = remain_dec;
                res0.x      = src_step;
                res0.y      = dst_step;
                res0.dbank  = dbank_reg;
                res0.cyc    = CYC_BYTE;

                res1.acc    = remain_dec;
                res1.x      = src_step;
                res1.y      = dst_step;
                res1.dbank  = dbank_reg;
                res1.last   = 1'b1;
                if (remain_dec == COUNT_END)
                begin
                    moving_next = 1'b0;
                    res1.kind   = KIND_DONE;
                    res1.pc_adv = 2'd3;
                end
                else
                begin
                    res1.kind   = KIND_READ;
                    res1.addr   = {sbank_reg, src_step};
                end
            end
        end
        else
        begin
            // A new instruction abandons any move in progress
            moving_next = 1'b0;
            res_n       = 2'd1;
            res0.kind   = KIND_DONE;
            res0.acc    = acc_reg;
            res0.x      = x_reg;
            res0.y      = y_reg;
            res0.last   = 1'b1;
            unique case (instr_reg)
                OP_XBA:
                begin
                    res0.kind   = KIND_DONE_NZ;
                    res0.acc    = {acc_reg[7:0], acc_hi};
                    res0.nz     = {acc_hi[7], (acc_hi == 8'h00)};
                    res0.pc_adv = 2'd1;
                    res0.cyc    = CYC_THREE;
                end
                OP_STP:
                begin
                    res0.pc_adv = 2'd1;
                    res0.cyc    = CYC_THREE;
                    res0.ev     = EV_STOP;
                end
                OP_WAI:
                begin
                    res0.pc_adv = 2'd1;
                    res0.cyc    = CYC_THREE;
                    res0.ev     = EV_WAIT;
                end
                OP_WDM:
                begin
                    res0.pc_adv = 2'd2;
                    res0.cyc    = CYC_TWO;
                end
                OP_NOP:
                begin
                    res0.pc_adv = 2'd1;
                    res0.cyc    = CYC_TWO;
                end
                OP_MVP, OP_MVN:
                begin
                    moving_next  = 1'b1;
                    down_next    = (instr_reg == OP_MVP);
                    remain_next  = acc_reg;
                    src_off_next = x_reg;
                    dst_off_next = y_reg;
                    sbank_next   = sbank_in_reg;
                    dbank_next   = dbank_in_reg;
                    res0.kind    = KIND_READ;
                    res0.addr    = {sbank_in_reg, x_reg};
                    res0.dbank   = dbank_in_reg;
                end
                default:
                begin
                    res0.ev     = EV_UNEXP;
                    res0.cyc    = CYC_NONE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result buffer update: load a new pair or shift the tail forward
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (advance)
        begin
            cnt_next   = res_n;
            slot0_next = res0;
            slot1_next = res1;
        end
        else if (out_accept)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            moving_reg  <= 1'b0;
            down_reg    <= 1'b0;
            remain_reg  <= '0;
            src_off_reg <= '0;
            dst_off_reg <= '0;
            sbank_reg   <= '0;
            dbank_reg   <= '0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            cnt_reg     <= cnt_next;
            // Commit move state only when the held beat advances
            if (advance)
            begin
                moving_reg  <= moving_next;
                down_reg    <= down_next;
                remain_reg  <= remain_next;
                src_off_reg <= src_off_next;
                dst_off_reg <= dst_off_next;
                sbank_reg   <= sbank_next;
                dbank_reg   <= dbank_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= opcode;
            instr_reg    <= instruction;
            dbank_in_reg <= dest_bank;
            sbank_in_reg <= src_bank;
            acc_reg      <= acc_in;
            x_reg        <= x_in;
            y_reg        <= y_in;
            rdata_reg    <= read_data;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // ------------------------------------------------------------------
    // Output beat
    // ------------------------------------------------------------------
    assign out_valid   = (cnt_reg != 2'd0);
    assign result_kind = slot0_reg.kind;
    assign bus_address = slot0_reg.addr;
    assign write_data  = slot0_reg.wdata;
    assign acc_out     = slot0_reg.acc;
    assign x_out       = slot0_reg.x;
    assign y_out       = slot0_reg.y;
    assign data_bank   = slot0_reg.dbank;
    assign nz_flags    = slot0_reg.nz;
    assign pc_advance  = slot0_reg.pc_adv;
    assign cycles      = slot0_reg.cyc;
    assign event_res   = slot0_reg.ev;
    assign last        = slot0_reg.last;

endmodule

`default_nettype wire

FILE: rtl/mibm_checker.sv
// ============================================================================
// mibm_checker - port-level checks for the misc instruction / block move unit
// Watches the output beats of the core and flags inconsistent results.
// ============================================================================
`default_nettype none

module mibm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  result_kind,
    input wire logic [23:0] bus_address,
    input wire logic [2:0]  cycles,
    input wire logic [1:0]  pc_advance,
    input wire logic        last
);

    import mibm_pkg::*;

    // A write beat is always followed by another beat of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_WRITE) |-> (!last && cycles == CYC_BYTE))
    else $error("write beat must charge a byte and not be last");

    // A read request ends its item and charges nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_READ) |-> (last && cycles == CYC_NONE
            && pc_advance == 2'd0))
    else $error("read beat must be last with no cycles or pc advance");

    // After an accepted write, its companion beat is shown the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && result_kind == KIND_WRITE)
            |=> (out_valid && last && (result_kind == KIND_READ
                || result_kind == KIND_DONE)))
    else $error("write beat not followed by read or completion");

    // Stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(bus_address)
            && $stable(result_kind)))
    else $error("stalled output beat changed");

endmodule

bind misc_instruction_and_block_move_unit_core mibm_checker u_mibm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .bus_address (bus_address),
    .cycles      (cycles),
    .pc_advance  (pc_advance),
    .last        (last)
);

`default_nettype wire

FILE: test/tb_misc_instruction_and_block_move_unit_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_misc_instruction_and_block_move_unit_core - self-checking bench of the unit
// Drives a directed table and then random instruction and block-move traffic
// through the valid/stall channels. Every result beat is checked against a
// hand-written result or a cycle-free predictor of the instruction and move
// logic. Sender gaps and receiver stalls change from phase to phase.
// ============================================================================

module tb_misc_instruction_and_block_move_unit_core;

    import mibm_pkg::*;

    // Generous watchdog on the length of the whole run
    localparam int CYCLE_LIMIT    = 4000000;
    // Cycles to keep watching the output once nothing is expected
    localparam int SETTLE_CYCLES  = 32;
    localparam int ITEMS_PER_PHASE = 463;

    // One input beat, in port order
    typedef struct packed {
        logic        op;
        logic [7:0]  instr;
        logic [7:0]  dbank;
        logic [7:0]  sbank;
        logic [15:0] acc;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  rd;
    } item_t;

    // Directed row: stimulus plus an optional hand-written result
    typedef struct {
        item_t   it;
        bit      fixed;
        result_t beat;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        opcode      = 1'b0;
    logic [7:0]  instruction = 8'h00;
    logic [7:0]  dest_bank   = 8'h00;
    logic [7:0]  src_bank    = 8'h00;
    logic [15:0] acc_in      = 16'h0000;
    logic [15:0] x_in        = 16'h0000;
    logic [15:0] y_in        = 16'h0000;
    logic [7:0]  read_data   = 8'h00;

    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  result_kind;
    logic [23:0] bus_address;
    logic [7:0]  write_data;
    logic [15:0] acc_out;
    logic [15:0] x_out;
    logic [15:0] y_out;
    logic [7:0]  data_bank;
    logic [1:0]  nz_flags;
    logic [1:0]  pc_advance;
    logic [2:0]  cycles;
    logic [1:0]  event_res;
    logic        last;

    misc_instruction_and_block_move_unit_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .instruction (instruction),
        .dest_bank   (dest_bank),
        .src_bank    (src_bank),
        .acc_in      (acc_in),
        .x_in        (x_in),
        .y_in        (y_in),
        .read_data   (read_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .bus_address (bus_address),
        .write_data  (write_data),
        .acc_out     (acc_out),
        .x_out       (x_out),
        .y_out       (y_out),
        .data_bank   (data_bank),
        .nz_flags    (nz_flags),
        .pc_advance  (pc_advance),
        .cycles      (cycles),
        .event_res   (event_res),
        .last        (last)
    );

    always #5 clk = ~clk;

    // Expected result beats, oldest first
    result_t pending_beats [$];
    dir_row_t dir_rows [$];

    int idle_pct   = 0;
    int stall_pct  = 0;
    int fail_count = 0;
    int cycle_cnt  = 0;

    // Predictor copy of the move sequencer state
    logic        mv_active   = 1'b0;
    logic        mv_down     = 1'b0;
    logic [15:0] mv_count    = 16'h0000;
    logic [15:0] mv_src_ofs  = 16'h0000;
    logic [15:0] mv_dst_ofs  = 16'h0000;
    logic [7:0]  mv_src_bank = 8'h00;
    logic [7:0]  mv_dst_bank = 8'h00;

    function automatic result_t mk_beat(input logic [1:0] kind, input logic [23:0] addr,
                                        input logic [7:0] wd, input logic [15:0] acc,
                                        input logic [15:0] x, input logic [15:0] y,
                                        input logic [7:0] db, input logic [1:0] nz,
                                        input logic [1:0] pc, input logic [2:0] cyc,
                                        input logic [1:0] ev, input logic lst);
        result_t r;
        r.kind   = kind;
        r.addr   = addr;
        r.wdata  = wd;
        r.acc    = acc;
        r.x      = x;
        r.y      = y;
        r.dbank  = db;
        r.nz     = nz;
        r.pc_adv = pc;
        r.cyc    = cyc;
        r.ev     = ev;
        r.last   = lst;
        return r;
    endfunction

    // Read request for the next source byte of the running move
    function automatic result_t source_read();
        return mk_beat(KIND_READ, {mv_src_bank, mv_src_ofs}, 8'h00, mv_count,
                       mv_src_ofs, mv_dst_ofs, mv_dst_bank, 2'b00, 2'd0,
                       CYC_NONE, EV_NONE, 1'b1);
    endfunction

    function automatic item_t instr_item(input logic [7:0] ins, input logic [7:0] db,
                                         input logic [7:0] sb, input logic [15:0] a,
                                         input logic [15:0] x, input logic [15:0] y);
        item_t it;
        it       = '0;
        it.op    = ITEM_INSTR;
        it.instr = ins;
        it.dbank = db;
        it.sbank = sb;
        it.acc   = a;
        it.x     = x;
        it.y     = y;
        return it;
    endfunction

    function automatic item_t data_item(input logic [7:0] rd);
        item_t it;
        it    = '0;
        it.op = ITEM_DATA;
        it.rd = rd;
        return it;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.op    = 1'($urandom_range(0, 1));
        it.instr = 8'($urandom);
        it.dbank = 8'($urandom);
        it.sbank = 8'($urandom);
        it.acc   = 16'($urandom);
        it.x     = 16'($urandom);
        it.y     = 16'($urandom);
        it.rd    = 8'($urandom);
        return it;
    endfunction

    // Work out the result beats one accepted input causes and advance the
    // predictor state. n is 0, 1 or 2.
    task automatic compute_beats(input item_t it, output result_t r0, output result_t r1,
                                 output int n);
        logic [23:0] waddr;
        logic [7:0]  hi;
        r0 = '0;
        r1 = '0;
        n  = 0;
        if (it.op == ITEM_DATA) begin
            // A stray byte with no move running is dropped silently
            if (mv_active) begin
                waddr = {mv_dst_bank, mv_dst_ofs};
                if (mv_down) begin
                    mv_src_ofs = mv_src_ofs - 16'd1;
                    mv_dst_ofs = mv_dst_ofs - 16'd1;
                end
                else begin
                    mv_src_ofs = mv_src_ofs + 16'd1;
                    mv_dst_ofs = mv_dst_ofs + 16'd1;
                end
                mv_count = mv_count - 16'd1;
                r0 = mk_beat(KIND_WRITE, waddr, it.rd, mv_count, mv_src_ofs, mv_dst_ofs,
                             mv_dst_bank, 2'b00, 2'd0, CYC_BYTE, EV_NONE, 1'b0);
                // Count is tested after the copy: end once it wraps past zero
                if (mv_count == COUNT_END) begin
                    mv_active = 1'b0;
                    r1 = mk_beat(KIND_DONE, 24'h000000, 8'h00, mv_count, mv_src_ofs,
                                 mv_dst_ofs, mv_dst_bank, 2'b00, 2'd3, CYC_NONE,
                                 EV_NONE, 1'b1);
                end
                else begin
                    r1 = source_read();
                end
                n = 2;
            end
        end
        else begin
            // Any new instruction abandons a running move
            mv_active = 1'b0;
            n = 1;
            case (it.instr)
                OP_XBA:
                begin
                    hi = it.acc[15:8];
                    r0 = mk_beat(KIND_DONE_NZ, 24'h000000, 8'h00, {it.acc[7:0], hi},
                                 it.x, it.y, 8'h00, {hi[7], hi == 8'h00}, 2'd1,
                                 CYC_THREE, EV_NONE, 1'b1);
                end
                OP_STP:
                    r0 = mk_beat(KIND_DONE, 24'h000000, 8'h00, it.acc, it.x, it.y, 8'h00,
                                 2'b00, 2'd1, CYC_THREE, EV_STOP, 1'b1);
                OP_WAI:
                    r0 = mk_beat(KIND_DONE, 24'h000000, 8'h00, it.acc, it.x, it.y, 8'h00,
                                 2'b00, 2'd1, CYC_THREE, EV_WAIT, 1'b1);
                OP_WDM:
                    r0 = mk_beat(KIND_DONE, 24'h000000, 8'h00, it.acc, it.x, it.y, 8'h00,
                                 2'b00, 2'd2, CYC_TWO, EV_NONE, 1'b1);
                OP_NOP:
                    r0 = mk_beat(KIND_DONE, 24'h000000, 8'h00, it.acc, it.x, it.y, 8'h00,
                                 2'b00, 2'd1, CYC_TWO, EV_NONE, 1'b1);
                OP_MVP, OP_MVN:
                begin
                    mv_active   = 1'b1;
                    mv_down     = (it.instr == OP_MVP);
                    mv_count    = it.acc;
                    mv_src_ofs  = it.x;
                    mv_dst_ofs  = it.y;
                    mv_src_bank = it.sbank;
                    mv_dst_bank = it.dbank;
                    r0 = source_read();
                end
                default:
                    r0 = mk_beat(KIND_DONE, 24'h000000, 8'h00, it.acc, it.x, it.y, 8'h00,
                                 2'b00, 2'd0, CYC_NONE, EV_UNEXP, 1'b1);
            endcase
        end
    endtask

    // Present one beat after a random gap, hold it until accepted, then queue
    // what it should produce. Returns at the accepting edge without advancing
    // time, so the caller may drive the next beat in the same step.
    task automatic send_item(input item_t it, input bit fixed, input result_t fixed_beat,
                             output int n);
        result_t r0, r1;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.op;
        instruction <= it.instr;
        dest_bank   <= it.dbank;
        src_bank    <= it.sbank;
        acc_in      <= it.acc;
        x_in        <= it.x;
        y_in        <= it.y;
        read_data   <= it.rd;
        @(posedge clk);
        // Hold the payload steady while the unit stalls
        while (in_stall) @(posedge clk);
        compute_beats(it, r0, r1, n);
        if (fixed) begin
            pending_beats.push_back(fixed_beat);
        end
        else begin
            if (n > 0) pending_beats.push_back(r0);
            if (n > 1) pending_beats.push_back(r1);
        end
    endtask

    // Drop valid and hold off until every expected beat has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
    endtask

    task automatic add_row(input item_t it, input bit fixed, input result_t beat);
        dir_row_t row;
        row.it    = it;
        row.fixed = fixed;
        row.beat  = beat;
        dir_rows.push_back(row);
    endtask

    // Random traffic: mostly complete block moves with random content, plus
    // single instructions, abandoned moves and stray bytes. Only beats that
    // produce results count toward the target.
    task automatic run_random(input int target);
        int     made;
        int     r;
        int     cnt;
        int     nbytes;
        int     n;
        item_t  it;
        item_t  d;
        made = 0;
        while (made < target) begin
            r  = $urandom_range(0, 99);
            it = rand_item();
            it.op = ITEM_INSTR;
            if (r < 70) begin
                it.instr = $urandom_range(0, 1) ? OP_MVP : OP_MVN;
                // Short counts mostly; now and then a longer copy
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 4);
                it.acc = 16'(cnt);
                // Park the offsets near the bank edge to force wraps
                if ($urandom_range(0, 2) == 0) it.x = 16'hFFFE + 16'($urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) it.y = 16'hFFFE + 16'($urandom_range(0, 3));
                nbytes = cnt + 1;
                if (r >= 55) begin
                    // Broken move: cut short by whatever comes next
                    nbytes = $urandom_range(0, cnt);
                    if ($urandom_range(0, 3) == 0) it.acc = 16'($urandom);
                end
                send_item(it, 1'b0, '0, n);
                if (n > 0) made++;
                for (int k = 0; k < nbytes; k++) begin
                    d = rand_item();
                    d.op = ITEM_DATA;
                    send_item(d, 1'b0, '0, n);
                    if (n > 0) made++;
                end
            end
            else if (r < 92) begin
                case ($urandom_range(0, 9))
                    0: it.instr = OP_XBA;
                    1: it.instr = OP_STP;
                    2: it.instr = OP_WAI;
                    3: it.instr = OP_WDM;
                    4: it.instr = OP_NOP;
                    5: it.instr = OP_MVP;
                    6: it.instr = OP_MVN;
                    default: it.instr = 8'($urandom);
                endcase
                send_item(it, 1'b0, '0, n);
                if (n > 0) made++;
            end
            else begin
                it.op = ITEM_DATA;
                send_item(it, 1'b0, '0, n);
                if (n > 0) made++;
            end
        end
    endtask

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL misc_instruction_and_block_move_unit_core");
            $finish;
        end
    end

    // Result side: check every accepted beat against the oldest expectation,
    // then pick the stall for the next cycle.
    always @(posedge clk) begin : check_results
        result_t got;
        result_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {result_kind, bus_address, write_data, acc_out, x_out, y_out,
                       data_bank, nz_flags, pc_advance, cycles, event_res, last};
                if (pending_beats.size() == 0) begin
                    if (fail_count < 10)
                        $display("cycle %0d: result beat with nothing expected: %p",
                                 cycle_cnt, got);
                    fail_count++;
                end
                else begin
                    want = pending_beats.pop_front();
                    // Packed compare covers every field of the beat
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("cycle %0d: mismatch\n  expected %p\n  actual   %p",
                                     cycle_cnt, want, got);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin : stimulus
        int    n;

        // --- directed table ---
        // Hand-written results where they follow straight from the opcode;
        // the rest go through the predictor.
        add_row(instr_item(OP_XBA, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
                mk_beat(KIND_DONE_NZ, 24'h000000, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'h00, 2'b01, 2'd1, CYC_THREE, EV_NONE, 1'b1));
        add_row(instr_item(OP_XBA, 8'hFF, 8'hFF, 16'h80FF, 16'hFFFF, 16'hFFFF), 1'b1,
                mk_beat(KIND_DONE_NZ, 24'h000000, 8'h00, 16'hFF80, 16'hFFFF, 16'hFFFF,
                        8'h00, 2'b10, 2'd1, CYC_THREE, EV_NONE, 1'b1));
        add_row(instr_item(OP_XBA, 8'h00, 8'h00, 16'h7F00, 16'h1234, 16'h4321), 1'b1,
                mk_beat(KIND_DONE_NZ, 24'h000000, 8'h00, 16'h007F, 16'h1234, 16'h4321,
                        8'h00, 2'b00, 2'd1, CYC_THREE, EV_NONE, 1'b1));
        add_row(instr_item(OP_STP, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF,
                        8'h00, 2'b00, 2'd1, CYC_THREE, EV_STOP, 1'b1));
        add_row(instr_item(OP_WAI, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 16'h0000), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'h0000, 16'hFFFF, 16'h0000,
                        8'h00, 2'b00, 2'd1, CYC_THREE, EV_WAIT, 1'b1));
        add_row(instr_item(OP_WDM, 8'hFF, 8'hFF, 16'h1234, 16'h5678, 16'h9ABC), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'h1234, 16'h5678, 16'h9ABC,
                        8'h00, 2'b00, 2'd2, CYC_TWO, EV_NONE, 1'b1));
        add_row(instr_item(OP_NOP, 8'h00, 8'h00, 16'hA55A, 16'h5AA5, 16'h0F0F), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'hA55A, 16'h5AA5, 16'h0F0F,
                        8'h00, 2'b00, 2'd1, CYC_TWO, EV_NONE, 1'b1));
        // Unknown opcodes pass A, X and Y through with no advance or cycles
        add_row(instr_item(8'h00, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        8'h00, 2'b00, 2'd0, CYC_NONE, EV_UNEXP, 1'b1));
        add_row(instr_item(8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
                mk_beat(KIND_DONE, 24'h000000, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                        8'h00, 2'b00, 2'd0, CYC_NONE, EV_UNEXP, 1'b1));
        // Stray byte with no move running: no result
        add_row(data_item(8'hFF), 1'b0, '0);
        // Count of zero still copies one byte; both offsets wrap past 0xFFFF
        add_row(instr_item(OP_MVN, 8'h00, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF), 1'b1,
                mk_beat(KIND_READ, 24'hFFFFFF, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF,
                        8'h00, 2'b00, 2'd0, CYC_NONE, EV_NONE, 1'b1));
        add_row(data_item(8'hA5), 1'b0, '0);
        // Three-byte descending move, offsets wrap below zero
        add_row(instr_item(OP_MVP, 8'h34, 8'h12, 16'h0002, 16'h0001, 16'h0000), 1'b0, '0);
        add_row(data_item(8'h00), 1'b0, '0);
        add_row(data_item(8'hFF), 1'b0, '0);
        add_row(data_item(8'h5A), 1'b0, '0);
        // Full-size count, abandoned by a new instruction
        add_row(instr_item(OP_MVN, 8'hCD, 8'hAB, 16'hFFFF, 16'h8000, 16'h1000), 1'b0, '0);
        add_row(data_item(8'h01), 1'b0, '0);
        add_row(data_item(8'h80), 1'b0, '0);
        add_row(instr_item(OP_NOP, 8'h00, 8'h00, 16'h0001, 16'h0002, 16'h0003), 1'b0, '0);
        add_row(data_item(8'h33), 1'b0, '0);
        add_row(instr_item(OP_MVP, 8'hFF, 8'h00, 16'h0005, 16'h0000, 16'h0000), 1'b0, '0);
        add_row(data_item(8'h7E), 1'b0, '0);
        add_row(instr_item(OP_XBA, 8'h00, 8'h00, 16'hFF00, 16'h0000, 16'h0000), 1'b0, '0);
        add_row(data_item(8'h11), 1'b0, '0);

        // Hold reset, then release it on a clock edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- phase 0: no idling on either side ---
        idle_pct  = 0;
        stall_pct = 0;
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].beat, n);
        run_random(ITEMS_PER_PHASE);
        // Let the pipe run dry before the next traffic pattern
        wait_drain();

        // --- phase 1: sender idle most of the time ---
        idle_pct  = 84;
        stall_pct = 0;
        run_random(ITEMS_PER_PHASE);
        wait_drain();

        // --- phase 2: receiver stalling most of the time ---
        idle_pct  = 0;
        stall_pct = 84;
        run_random(ITEMS_PER_PHASE);
        wait_drain();

        // --- phase 3: light idling on both sides ---
        idle_pct  = 12;
        stall_pct = 12;
        run_random(ITEMS_PER_PHASE);

        // Drain, then keep watching for stray beats
        stall_pct = 0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS misc_instruction_and_block_move_unit_core");
        else
            $display("FAIL misc_instruction_and_block_move_unit_core");
        $finish;
    end

endmodule

FILE: misc_instruction_and_block_move_unit_core.f
rtl/mibm_pkg.sv
rtl/misc_instruction_and_block_move_unit_core.sv
rtl/mibm_checker.sv
test/tb_misc_instruction_and_block_move_unit_core.sv
